>>> rtl/sdta_pkg.sv
package sdta_pkg;

	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned CONV_STEPS = 16;

	localparam logic [7:0] CHR_ZERO  = 8'd48;
	localparam logic [7:0] CHR_MINUS = 8'd45;

	typedef struct packed {
		logic clear;
		logic step;
		logic shift;
	} cell_ctl_t;

endpackage

>>> rtl/sdta_cell.sv
module sdta_cell
	import sdta_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      in1,
	input  logic      in2,
	input  logic [3:0] shift_in,
	output logic [3:0] digit,
	output logic      out1,
	output logic      out2
);

	logic [3:0] digit_q;
	logic [3:0] a1;
	logic [3:0] mid;
	logic [3:0] a2;

	function automatic logic [3:0] add3(input logic [3:0] x);
		return (x >= 4'd5) ? x + 4'd3 : x;
	endfunction

	// two double-dabble steps per cycle
	always_comb begin
		a1   = add3(digit_q);
		mid  = {a1[2:0], in1};
		a2   = add3(mid);
		out1 = a1[3];
		out2 = a2[3];
	end

	always_ff @(posedge clk) begin
		priority if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.step) begin
			digit_q <= {a2[2:0], in2};
		end else if (ctl.shift) begin
			digit_q <= shift_in;
		end
	end

	assign digit = digit_q;

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// channel | dir | tdata bits          | tuser | tlast
// s_      | in  | [31:0] value        | -     | -
// m_      | out | [7:0]  character    | -     | last
//
// One number at a time. Accept, then BCD conversion (2 bits per cycle through a
// row of 10 digit cells), then up to 9 leading zeros dropped, then one beat per
// character. arst_n clears control state. Output stalls hold the row.
module signed_int_to_decimal_ascii
	import sdta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] character
	output logic        m_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t      state_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [3:0]  cnt_q;
	logic [3:0]  left_q;

	cell_ctl_t   ctl;
	logic [3:0]  digit [NUM_DIGITS];
	logic        out1  [NUM_DIGITS];
	logic        out2  [NUM_DIGITS];
	logic [3:0]  top;
	logic        out_free;
	logic        accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign top      = digit[NUM_DIGITS-1];

	always_comb begin
		ctl.clear = accept;
		ctl.step  = (state_q == ST_CONV);
		ctl.shift = ((state_q == ST_SKIP) && (top == 4'd0) && (left_q > 4'd1)) ||
			((state_q == ST_EMIT) && out_free);
	end

	for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
		logic       c_in1;
		logic       c_in2;
		logic [3:0] c_shift;
		if (k == 0) begin : g_first
			assign c_in1   = mag_q[31];
			assign c_in2   = mag_q[30];
			assign c_shift = 4'd0;
		end else begin : g_rest
			assign c_in1   = out1[k-1];
			assign c_in2   = out2[k-1];
			assign c_shift = digit[k-1];
		end
		sdta_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.in1      (c_in1),
			.in2      (c_in2),
			.shift_in (c_shift),
			.digit    (digit[k]),
			.out1     (out1[k]),
			.out2     (out2[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			left_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (((state_q == ST_SIGN) || (state_q == ST_EMIT)) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(CONV_STEPS - 1)) begin
						left_q  <= 4'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctl.shift) begin
						left_q <= left_q - 4'd1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						left_q <= left_q - 4'd1;
						if (left_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= s_tdata[31];
			mag_q <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[29:0], 2'b00};
		end
		if ((state_q == ST_SIGN) && out_free) begin
			m_tdata <= CHR_MINUS;
			m_tlast <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			m_tdata <= CHR_ZERO + {4'd0, top};
			m_tlast <= (left_q == 4'd1);
		end
	end

	a_emit_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top <= 4'd9))
		else $error("non-decimal digit at head of row");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SKIP) || (state_q == ST_SIGN) || (state_q == ST_EMIT))
		|-> (left_q != 4'd0))
		else $error("digit count ran out");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (cnt_q == 4'd0))
		else $error("accept did not start conversion");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("beat after last character of a number");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import sdta_pkg::*;

	localparam int unsigned DECIMAL_BASE = 10;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 250;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS  = 20;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} char_beat_t;

	typedef struct {
		logic [31:0] value;
		string       text;
	} number_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	char_beat_t  pending_chars[$];
	int unsigned error_count;
	int unsigned numbers_sent;
	int unsigned chars_seen;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned hold_left;
	number_row_t directed_rows[16];

	signed_int_to_decimal_ascii DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void predict_decimal_text(input logic [31:0] value);
		logic [31:0] mag;
		logic [7:0]  digits[$];
		mag = value[31] ? (32'd0 - value) : value;
		do begin
			digits.push_front(CHR_ZERO + 8'(mag % DECIMAL_BASE));
			mag = mag / DECIMAL_BASE;
		end while (mag != 32'd0);
		if (value[31])
			pending_chars.push_back('{character: CHR_MINUS, last: 1'b0});
		foreach (digits[i])
			pending_chars.push_back('{character: digits[i], last: i == digits.size() - 1});
	endfunction

	function automatic void expect_literal_text(input string text);
		for (int i = 0; i < text.len(); i++)
			pending_chars.push_back('{character: text[i], last: i == text.len() - 1});
	endfunction

	function automatic logic [31:0] pick_number();
		logic [31:0] v;
		longint unsigned scale;
		int unsigned d;
		d = $urandom_range(1, 9);
		scale = 1;
		for (int i = 0; i < d; i++)
			scale = scale * DECIMAL_BASE;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = 32'($urandom % scale);
			2: v = 32'(scale) - 32'($urandom_range(0, 1));
			default: v = $urandom_range(0, 20);
		endcase
		if ($urandom_range(0, 1))
			v = 32'd0 - v;
		return v;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_number(input logic [31:0] value, input string text);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		if (text.len() > 0)
			expect_literal_text(text);
		else
			predict_decimal_text(value);
		numbers_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_chars.size() != 0);
	endtask

	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (PHASE_ITEMS)
			send_number(pick_number(), "");
		wait_drained();
	endtask

	// receiver side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected beat char=%0d last=%0b", m_tdata, m_tlast));
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.character)
					report_mismatch($sformatf("char %0d, expected %0d", m_tdata, want.character));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
			pending_chars.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		error_count    = 0;
		numbers_sent   = 0;
		chars_seen     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_requests  = 0;
		hold_served    = 0;
		hold_left      = 0;

		directed_rows = '{
			'{32'd0,          "0"},
			'{32'd1,          "1"},
			'{32'd9,          "9"},
			'{32'd10,         "10"},
			'{-32'sd1,        "-1"},
			'{-32'sd10,       "-10"},
			'{32'd100,        "100"},
			'{32'd999999999,  "999999999"},
			'{32'd1000000000, "1000000000"},
			'{32'h7FFF_FFFF,  "2147483647"},
			'{32'h8000_0000,  "-2147483648"},
			'{32'h8000_0001,  "-2147483647"},
			'{32'h5555_5555,  ""},
			'{32'hAAAA_AAAA,  ""},
			'{32'd12345,      ""},
			'{-32'sd987654,   ""}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_number(directed_rows[i].value, directed_rows[i].text);
		wait_drained();

		// long output hold-off while inputs keep coming
		hold_requests++;
		repeat (6)
			send_number(pick_number(), "");
		wait_drained();

		run_random_phase(0, 0);
		run_random_phase(71, 0);
		run_random_phase(0, 71);
		run_random_phase(17, 17);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", pending_chars.size()));

		$display("Converted %0d numbers into %0d characters in %0d cycles,", numbers_sent,
			chars_seen, cycle_count);
		$display("covering extremes, zero, both signs, input and output stalls, long hold-off.");
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
